// ===== sv/jeos_pkg.sv =====
// Shared types and constants for the EXIF orientation scanner.
package jeos_pkg;

   localparam logic [7:0] MARKER_PREFIX = 8'hFF;
   localparam logic [7:0] MARKER_SOI    = 8'hD8;
   localparam logic [7:0] MARKER_APP1   = 8'hE1;
   localparam logic [7:0] EXIF_CHAR_E   = 8'h45;
   localparam logic [7:0] EXIF_CHAR_X   = 8'h78;
   localparam logic [7:0] EXIF_CHAR_I   = 8'h69;
   localparam logic [7:0] EXIF_CHAR_F   = 8'h66;
   localparam logic [7:0] EXIF_PAD      = 8'h00;
   localparam logic [7:0] BOM_LITTLE    = 8'h49;
   localparam logic [7:0] BOM_BIG       = 8'h4D;
   localparam logic [15:0] TIFF_MAGIC   = 16'h002A;
   localparam logic [15:0] TAG_ORIENT   = 16'h0112;
   localparam logic [15:0] ORIENT_RIGHT = 16'h0006;
   localparam logic [15:0] ORIENT_LEFT  = 16'h0008;

   localparam logic [1:0] ROT_UPRIGHT = 2'd0;
   localparam logic [1:0] ROT_RIGHT   = 2'd1;
   localparam logic [1:0] ROT_LEFT    = 2'd3;

   localparam int POS_W = 33;
   localparam logic [POS_W-1:0] TIFF_BASE  = 33'd12;
   localparam logic [POS_W-1:0] HEADER_LEN = 33'd20;

   // one input byte as held in the input register
   typedef struct packed {
      logic [7:0] byte_value;
      logic       end_of_file;
   } step_type;

   // verdict for the current byte
   typedef struct packed {
      logic       valid;
      logic [1:0] rotation;
      logic       failed;
   } result_type;

endpackage

// ===== sv/jeos_parser.sv =====
// Per-byte parse state and next-state logic of the EXIF orientation scanner.
module jeos_parser (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  jeos_pkg::step_type    item,
   output jeos_pkg::result_type  result
);

   typedef enum logic [2:0] {
      PH_HEADER,
      PH_SKIP,
      PH_COUNT,
      PH_ENTRIES,
      PH_DONE
   } phase_type;

   phase_type                     phase_ff, phase_in;
   logic [jeos_pkg::POS_W-1:0]    position_ff, position_in;
   logic [jeos_pkg::POS_W-1:0]    skip_target_ff, skip_target_in;
   logic                          lsb_first_ff, lsb_first_in;
   logic [31:0]                   assembly_ff, assembly_in;
   logic [15:0]                   entries_left_ff, entries_left_in;
   logic [3:0]                    entry_index_ff, entry_index_in;
   logic                          tag_matches_ff, tag_matches_in;

   logic       fail;
   logic       found;
   logic [1:0] rot;
   logic [7:0] b;

   // merge one byte into the assembly word in the active byte order
   function automatic logic [31:0] gather(input logic [1:0] k, input logic [7:0] v,
                                          input logic [31:0] w, input logic le);
      logic [31:0] base;
      base = (k == 2'd0) ? 32'd0 : w;
      if (le) begin
         gather = base | ({24'd0, v} << {k, 3'b000});
      end else begin
         gather = {base[23:0], v};
      end
   endfunction

   always_comb begin
      phase_in         = phase_ff;
      position_in      = position_ff;
      skip_target_in   = skip_target_ff;
      lsb_first_in     = lsb_first_ff;
      assembly_in      = assembly_ff;
      entries_left_in  = entries_left_ff;
      entry_index_in   = entry_index_ff;
      tag_matches_in   = tag_matches_ff;
      fail             = 1'b0;
      found            = 1'b0;
      rot              = jeos_pkg::ROT_UPRIGHT;
      b                = item.byte_value;

      // reached the entry count: leave the skip phase on this byte
      if (phase_ff == PH_SKIP && position_ff == skip_target_ff) begin
         phase_in       = PH_COUNT;
         entry_index_in = 4'd0;
      end

      case (phase_in)
         PH_HEADER: begin
            position_in = position_ff + 33'd1;
            case (position_ff[4:0])
               5'd0:  fail = (b != jeos_pkg::MARKER_PREFIX);
               5'd1:  fail = (b != jeos_pkg::MARKER_SOI);
               5'd2:  fail = (b != jeos_pkg::MARKER_PREFIX);
               5'd3:  fail = (b != jeos_pkg::MARKER_APP1);
               5'd4, 5'd5: fail = 1'b0;
               5'd6:  fail = (b != jeos_pkg::EXIF_CHAR_E);
               5'd7:  fail = (b != jeos_pkg::EXIF_CHAR_X);
               5'd8:  fail = (b != jeos_pkg::EXIF_CHAR_I);
               5'd9:  fail = (b != jeos_pkg::EXIF_CHAR_F);
               5'd10, 5'd11: fail = (b != jeos_pkg::EXIF_PAD);
               5'd12: assembly_in = {24'd0, b};
               5'd13: begin
                  if (b != assembly_ff[7:0]) begin
                     fail = 1'b1;
                  end else if (b == jeos_pkg::BOM_LITTLE) begin
                     lsb_first_in = 1'b1;
                  end else if (b == jeos_pkg::BOM_BIG) begin
                     lsb_first_in = 1'b0;
                  end else begin
                     fail = 1'b1;
                  end
               end
               5'd14, 5'd15: begin
                  assembly_in = gather({1'b0, position_ff[0]}, b, assembly_ff,
                                       lsb_first_ff);
                  fail = position_ff[0] && (assembly_in[15:0] != jeos_pkg::TIFF_MAGIC);
               end
               5'd16, 5'd17, 5'd18: begin
                  assembly_in = gather(position_ff[1:0], b, assembly_ff,
                                       lsb_first_ff);
               end
               default: begin
                  assembly_in    = gather(2'd3, b, assembly_ff, lsb_first_ff);
                  skip_target_in = jeos_pkg::TIFF_BASE + {1'b0, assembly_in};
                  if (skip_target_in < jeos_pkg::HEADER_LEN) begin
                     fail = 1'b1;
                  end else begin
                     phase_in = PH_SKIP;
                  end
               end
            endcase
         end
         PH_SKIP: begin
            position_in = position_ff + 33'd1;
         end
         PH_COUNT: begin
            assembly_in = gather(entry_index_in[1:0], b, assembly_ff, lsb_first_ff);
            if (entry_index_in == 4'd0) begin
               entry_index_in = 4'd1;
            end else begin
               entries_left_in = assembly_in[15:0];
               entry_index_in  = 4'd0;
               if (assembly_in[15:0] == 16'd0) begin
                  fail = 1'b1;
               end else begin
                  phase_in = PH_ENTRIES;
               end
            end
         end
         PH_ENTRIES: begin
            // tag in bytes 0-1, value in bytes 8-9 of each entry
            if (entry_index_ff <= 4'd1) begin
               assembly_in = gather(entry_index_ff[1:0], b, assembly_ff,
                                    lsb_first_ff);
               if (entry_index_ff == 4'd1) begin
                  tag_matches_in = (assembly_in[15:0] == jeos_pkg::TAG_ORIENT);
               end
            end else if (entry_index_ff == 4'd8 || entry_index_ff == 4'd9) begin
               assembly_in = gather(entry_index_ff[1:0], b, assembly_ff,
                                    lsb_first_ff);
            end
            if (entry_index_ff >= 4'd11) begin
               entry_index_in = 4'd0;
               if (tag_matches_ff) begin
                  found = 1'b1;
                  if (assembly_ff[15:0] == jeos_pkg::ORIENT_LEFT) begin
                     rot = jeos_pkg::ROT_LEFT;
                  end else if (assembly_ff[15:0] == jeos_pkg::ORIENT_RIGHT) begin
                     rot = jeos_pkg::ROT_RIGHT;
                  end else begin
                     rot = jeos_pkg::ROT_UPRIGHT;
                  end
               end else begin
                  entries_left_in = entries_left_ff - 16'd1;
                  fail = (entries_left_in == 16'd0);
               end
            end else begin
               entry_index_in = entry_index_ff + 4'd1;
            end
         end
         default: begin
         end
      endcase

      result.valid    = (phase_ff != PH_DONE) && (fail || found || item.end_of_file);
      result.rotation = found ? rot : jeos_pkg::ROT_UPRIGHT;
      result.failed   = !found;
      if (result.valid) begin
         phase_in = PH_DONE;
      end

      // rearm for the next file
      if (item.end_of_file) begin
         phase_in         = PH_HEADER;
         position_in      = '0;
         skip_target_in   = '0;
         lsb_first_in     = 1'b0;
         assembly_in      = '0;
         entries_left_in  = '0;
         entry_index_in   = '0;
         tag_matches_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_HEADER;
         position_ff      <= '0;
         skip_target_ff   <= '0;
         lsb_first_ff     <= 1'b0;
         assembly_ff      <= '0;
         entries_left_ff  <= '0;
         entry_index_ff   <= '0;
         tag_matches_ff   <= 1'b0;
      end else if (advance) begin
         phase_ff         <= phase_in;
         position_ff      <= position_in;
         skip_target_ff   <= skip_target_in;
         lsb_first_ff     <= lsb_first_in;
         assembly_ff      <= assembly_in;
         entries_left_ff  <= entries_left_in;
         entry_index_ff   <= entry_index_in;
         tag_matches_ff   <= tag_matches_in;
      end
   end

endmodule

// ===== sv/jpeg_exif_orientation_scanner_unit.sv =====
// Top level of the EXIF orientation scanner: input register, parser, result register.
//
//   channel | direction | ports                                        | moves
//   req     | in        | req_valid/req_ready, req_byte_value, req_end_of_file | one file byte
//   rsp     | out       | rsp_valid/rsp_ready, rsp_rotation, rsp_failed         | one verdict
//
// One byte a cycle sustained while results are taken. A byte is taken into the
// input register, parsed from there, and any verdict lands in the result
// register; a stalled result holds the byte in the input register until there
// is room for its verdict. The parser updates its state once per byte.
// Reset is synchronous and active high; it clears both registers and the parser.
// A stalled result holds the parser and input register; req_ready drops only
// when the input register is full and cannot move on.
module jpeg_exif_orientation_scanner_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_byte_value,
   input  logic       req_end_of_file,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_rotation,
   output logic       rsp_failed
);

   logic                 in_valid_ff;
   jeos_pkg::step_type   in_word_ff;
   logic                 rsp_valid_ff;
   logic [1:0]           rsp_rotation_ff;
   logic                 rsp_failed_ff;
   logic                 advance;
   jeos_pkg::result_type verdict;

   // parse the held word once there is room for its verdict
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   jeos_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (in_word_ff),
      .result  (verdict)
   );

   // input register: take a new word when empty or when the old one moves on
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_word_ff.byte_value  <= req_byte_value;
         in_word_ff.end_of_file <= req_end_of_file;
      end
   end

   // result register: load a verdict, drop it once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && verdict.valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && verdict.valid) begin
         rsp_rotation_ff <= verdict.rotation;
         rsp_failed_ff   <= verdict.failed;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_rotation = rsp_rotation_ff;
   assign rsp_failed   = rsp_failed_ff;

endmodule

// ===== sv/jeos_checker.sv =====
// Port-level checks for the EXIF orientation scanner, bound to its top level.
module jeos_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_rotation,
   input logic       rsp_failed
);

   // hold a stalled result word
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_rotation) && $stable(rsp_failed))
      else $error("stalled result word changed");

   // a failure carries no rotation
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_failed |-> rsp_rotation == jeos_pkg::ROT_UPRIGHT)
      else $error("failed result with nonzero rotation");

   // only the three defined rotation codes appear
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_rotation == jeos_pkg::ROT_UPRIGHT ||
                    rsp_rotation == jeos_pkg::ROT_RIGHT ||
                    rsp_rotation == jeos_pkg::ROT_LEFT)
      else $error("undefined rotation code");

   // reset empties the result register
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // with an empty result register the input side never stalls
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled while output was empty");

endmodule

bind jpeg_exif_orientation_scanner_unit jeos_checker u_jeos_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_ready    (req_ready),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_rotation (rsp_rotation),
   .rsp_failed   (rsp_failed)
);

// ===== tb/exif_orientation_checker.sv =====
// Checker for the EXIF orientation scanner: predicts each verdict and compares it on rsp.
module exif_orientation_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_ready,
   input  logic [7:0] req_byte_value,
   input  logic       req_end_of_file,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  logic [1:0] rsp_rotation,
   input  logic       rsp_failed,
   output int         error_count,
   output int         pending_results
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef enum logic [2:0] {
      SCAN_HEADER,
      SCAN_SKIP,
      SCAN_COUNT,
      SCAN_ENTRIES,
      SCAN_DONE
   } scan_phase_type;

   typedef struct packed {
      logic [1:0] rotation;
      logic       failed;
   } verdict_type;

   scan_phase_type             phase;
   logic [jeos_pkg::POS_W-1:0] byte_pos;
   logic [jeos_pkg::POS_W-1:0] count_start;
   logic                       lsb_first;
   logic [31:0]                field_word;
   logic [15:0]                entries_remaining;
   logic [3:0]                 entry_idx;
   logic                       tag_hit;
   logic                       verdict_given;
   verdict_type                verdict_q[$];

   function automatic void clear_scan();
      phase             = SCAN_HEADER;
      byte_pos          = '0;
      count_start       = '0;
      lsb_first         = 1'b0;
      field_word        = '0;
      entries_remaining = '0;
      entry_idx         = '0;
      tag_hit           = 1'b0;
      verdict_given     = 1'b0;
   endfunction

   // fold one byte into the multi-byte field in the current byte order
   function automatic void fold_byte(input int unsigned k, input logic [7:0] b);
      if (k == 0)
         field_word = '0;
      if (lsb_first)
         field_word = field_word | (32'(b) << (8 * (k % 4)));
      else
         field_word = {field_word[23:0], b};
   endfunction

   // returns 1 when the header byte breaks the expected layout
   function automatic logic header_byte_bad(input logic [7:0] b);
      logic [4:0] p;
      p        = byte_pos[4:0];
      byte_pos = byte_pos + 33'd1;
      case (p)
         5'd0, 5'd2: return b != jeos_pkg::MARKER_PREFIX;
         5'd1:       return b != jeos_pkg::MARKER_SOI;
         5'd3:       return b != jeos_pkg::MARKER_APP1;
         5'd4, 5'd5: return 1'b0;
         5'd6:       return b != jeos_pkg::EXIF_CHAR_E;
         5'd7:       return b != jeos_pkg::EXIF_CHAR_X;
         5'd8:       return b != jeos_pkg::EXIF_CHAR_I;
         5'd9:       return b != jeos_pkg::EXIF_CHAR_F;
         5'd10, 5'd11: return b != jeos_pkg::EXIF_PAD;
         5'd12: begin
            field_word = {24'd0, b};
            return 1'b0;
         end
         5'd13: begin
            if (b != field_word[7:0])
               return 1'b1;
            if (b == jeos_pkg::BOM_LITTLE)
               lsb_first = 1'b1;
            else if (b == jeos_pkg::BOM_BIG)
               lsb_first = 1'b0;
            else
               return 1'b1;
            return 1'b0;
         end
         5'd14, 5'd15: begin
            fold_byte(p - 5'd14, b);
            return p == 5'd15 && field_word[15:0] != jeos_pkg::TIFF_MAGIC;
         end
         5'd16, 5'd17, 5'd18: begin
            fold_byte(p - 5'd16, b);
            return 1'b0;
         end
         default: begin
            fold_byte(3, b);
            count_start = jeos_pkg::TIFF_BASE + {1'b0, field_word};
            if (count_start < jeos_pkg::HEADER_LEN)
               return 1'b1;
            phase = SCAN_SKIP;
            return 1'b0;
         end
      endcase
   endfunction

   function automatic void predict_verdict(input logic [7:0] b, input logic eof);
      logic        bad;
      logic        hit;
      logic [1:0]  rot;
      verdict_type v;
      bad = 1'b0;
      hit = 1'b0;
      rot = jeos_pkg::ROT_UPRIGHT;
      if (phase == SCAN_SKIP && byte_pos == count_start) begin
         phase     = SCAN_COUNT;
         entry_idx = '0;
      end
      case (phase)
         SCAN_HEADER: bad = header_byte_bad(b);
         SCAN_SKIP:   byte_pos = byte_pos + 33'd1;
         SCAN_COUNT: begin
            fold_byte(entry_idx, b);
            if (entry_idx == 0) begin
               entry_idx = 4'd1;
            end else begin
               entries_remaining = field_word[15:0];
               entry_idx         = '0;
               if (entries_remaining == 0)
                  bad = 1'b1;
               else
                  phase = SCAN_ENTRIES;
            end
         end
         SCAN_ENTRIES: begin
            if (entry_idx <= 1) begin
               fold_byte(entry_idx, b);
               if (entry_idx == 1)
                  tag_hit = field_word[15:0] == jeos_pkg::TAG_ORIENT;
            end else if (entry_idx == 8 || entry_idx == 9) begin
               fold_byte(entry_idx - 4'd8, b);
            end
            if (entry_idx >= 11) begin
               entry_idx = '0;
               if (tag_hit) begin
                  hit = 1'b1;
                  if (field_word[15:0] == jeos_pkg::ORIENT_LEFT)
                     rot = jeos_pkg::ROT_LEFT;
                  else if (field_word[15:0] == jeos_pkg::ORIENT_RIGHT)
                     rot = jeos_pkg::ROT_RIGHT;
               end else begin
                  entries_remaining = entries_remaining - 16'd1;
                  if (entries_remaining == 0)
                     bad = 1'b1;
               end
            end else begin
               entry_idx = entry_idx + 4'd1;
            end
         end
         default: ;
      endcase
      if (!verdict_given && (bad || hit || eof)) begin
         v.rotation = hit ? rot : jeos_pkg::ROT_UPRIGHT;
         v.failed   = !hit;
         verdict_q.push_back(v);
         verdict_given = 1'b1;
         phase         = SCAN_DONE;
      end
      if (eof)
         clear_scan();
   endfunction

   always @(posedge clock) begin : watch
      verdict_type want;
      if (reset) begin
         clear_scan();
         verdict_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (verdict_q.size() == 0) begin
               $error("unexpected verdict word: rotation %0d failed %0d",
                      rsp_rotation, rsp_failed);
               error_count++;
            end else begin
               want = verdict_q.pop_front();
               if (rsp_rotation !== want.rotation) begin
                  $error("rotation: expected %0d, got %0d", want.rotation, rsp_rotation);
                  error_count++;
               end
               if (rsp_failed !== want.failed) begin
                  $error("failed: expected %0d, got %0d", want.failed, rsp_failed);
                  error_count++;
               end
            end
         end
         if (req_valid && req_ready)
            predict_verdict(req_byte_value, req_end_of_file);
      end
      pending_results = verdict_q.size();
   end

endmodule

// ===== tb/tb_jpeg_exif_orientation_scanner_unit.sv =====
// Testbench top for the EXIF orientation scanner: file stimulus, pacing, watchdog, verdict.
module tb_jpeg_exif_orientation_scanner_unit;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RESET_CYCLES   = 5;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES   = 12;
   localparam int HOLD_CYCLES    = 400;
   localparam int TARGET_BYTES   = 1400;
   localparam int MIN_FILES      = 20;

   // receiver stall patterns
   typedef enum logic [1:0] {
      PACE_OPEN,
      PACE_COIN,
      PACE_THIRDS,
      PACE_SPARSE
   } pace_type;

   logic       clock           = 1'b0;
   logic       reset           = 1'b1;
   logic       req_valid       = 1'b0;
   logic       req_ready;
   logic [7:0] req_byte_value  = 8'h00;
   logic       req_end_of_file = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready       = 1'b0;
   logic [1:0] rsp_rotation;
   logic       rsp_failed;
   int         error_count;
   int         pending_results;

   pace_type   pace         = PACE_OPEN;
   int         pace_left    = 0;
   int         pace_tick    = 0;
   bit         hold_request = 1'b0;
   int         hold_left    = 0;
   int         burst_left   = 0;
   int         bytes_sent   = 0;
   logic [7:0] file_q[$];

   jpeg_exif_orientation_scanner_unit dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_byte_value  (req_byte_value),
      .req_end_of_file (req_end_of_file),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_rotation    (rsp_rotation),
      .rsp_failed      (rsp_failed)
   );

   exif_orientation_checker verdict_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_byte_value  (req_byte_value),
      .req_end_of_file (req_end_of_file),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_rotation    (rsp_rotation),
      .rsp_failed      (rsp_failed),
      .error_count     (error_count),
      .pending_results (pending_results)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ---------------------------------------------------------------
   // File assembly. Every file lands in file_q and goes out byte by
   // byte, with end_of_file on its last byte.
   // ---------------------------------------------------------------
   function automatic void push_half(input bit le, input logic [15:0] v);
      if (le) begin
         file_q.push_back(v[7:0]);
         file_q.push_back(v[15:8]);
      end else begin
         file_q.push_back(v[15:8]);
         file_q.push_back(v[7:0]);
      end
   endfunction

   function automatic void push_word(input bit le, input logic [31:0] v);
      if (le) begin
         push_half(le, v[15:0]);
         push_half(le, v[31:16]);
      end else begin
         push_half(le, v[31:16]);
         push_half(le, v[15:0]);
      end
   endfunction

   function automatic void push_random(input int n);
      repeat (n) file_q.push_back(8'($urandom));
   endfunction

   // drop bytes off the tail until n are left
   function automatic void cut_file(input int n);
      while (file_q.size() > n) void'(file_q.pop_back());
   endfunction

   // Build a complete APP1/TIFF file. tag_slot < 0 leaves the orientation
   // tag out; trailer bytes follow the last entry.
   function automatic void build_exif(input bit le, input logic [31:0] offset,
                                      input logic [15:0] count, input int n_entries,
                                      input int tag_slot, input logic [15:0] code,
                                      input int trailer);
      file_q.delete();
      file_q.push_back(jeos_pkg::MARKER_PREFIX);
      file_q.push_back(jeos_pkg::MARKER_SOI);
      file_q.push_back(jeos_pkg::MARKER_PREFIX);
      file_q.push_back(jeos_pkg::MARKER_APP1);
      push_random(2);
      file_q.push_back(jeos_pkg::EXIF_CHAR_E);
      file_q.push_back(jeos_pkg::EXIF_CHAR_X);
      file_q.push_back(jeos_pkg::EXIF_CHAR_I);
      file_q.push_back(jeos_pkg::EXIF_CHAR_F);
      file_q.push_back(jeos_pkg::EXIF_PAD);
      file_q.push_back(jeos_pkg::EXIF_PAD);
      file_q.push_back(le ? jeos_pkg::BOM_LITTLE : jeos_pkg::BOM_BIG);
      file_q.push_back(le ? jeos_pkg::BOM_LITTLE : jeos_pkg::BOM_BIG);
      push_half(le, jeos_pkg::TIFF_MAGIC);
      push_word(le, offset);
      // pad up to the entry count; a target past reach gets a short run only
      if (offset >= 32'd8 && offset <= 32'd1000)
         push_random(int'(offset) - 8);
      else if (offset > 32'd1000)
         push_random(10);
      push_half(le, count);
      for (int e = 0; e < n_entries; e++) begin
         push_half(le, e == tag_slot ? jeos_pkg::TAG_ORIENT : 16'($urandom));
         push_half(le, 16'($urandom));
         push_word(le, $urandom);
         push_half(le, e == tag_slot ? code : 16'($urandom));
         push_half(le, 16'($urandom));
      end
      push_random(trailer);
   endfunction

   function automatic logic [15:0] pick_code();
      case ($urandom_range(0, 6))
         0:       return jeos_pkg::ORIENT_RIGHT;
         1:       return jeos_pkg::ORIENT_LEFT;
         2:       return 16'h0000;
         3:       return 16'hFFFF;
         4:       return 16'h0001;
         5:       return jeos_pkg::ORIENT_LEFT | 16'h0100;
         default: return 16'($urandom);
      endcase
   endfunction

   // Mostly well-formed files with random content; the rest are cut,
   // corrupted, pointed backward or far ahead, empty of entries, or noise.
   function automatic void random_file();
      int          roll;
      bit          le;
      logic [31:0] offset;
      logic [15:0] count;
      int          n;
      int          slot;
      logic [7:0]  mark;
      roll = $urandom_range(0, 99);
      le   = 1'($urandom_range(0, 1));
      if (roll >= 92) begin
         file_q.delete();
         if ($urandom_range(0, 1)) begin
            file_q.push_back(jeos_pkg::MARKER_PREFIX);
            file_q.push_back(jeos_pkg::MARKER_SOI);
            file_q.push_back(jeos_pkg::MARKER_PREFIX);
            file_q.push_back(jeos_pkg::MARKER_APP1);
         end
         push_random($urandom_range(1, 24));
      end else if (roll >= 88) begin
         build_exif(le, 32'd8 + $urandom_range(0, 3), 16'd0, 0, -1, 16'd0,
                    $urandom_range(0, 3));
      end else if (roll >= 85) begin
         offset = $urandom_range(0, 3) == 0 ? 32'hFFFF_FFFF : ($urandom | 32'h8000_0000);
         build_exif(le, offset, 16'd1, 0, -1, 16'd0, 0);
      end else if (roll >= 80) begin
         build_exif(le, $urandom_range(0, 7), 16'd1, 1, 0, jeos_pkg::ORIENT_RIGHT, 3);
      end else begin
         offset = 32'd8 + ($urandom_range(0, 9) == 0 ? $urandom_range(0, 120)
                                                     : $urandom_range(0, 4));
         n      = $urandom_range(1, 4);
         count  = $urandom_range(0, 19) == 0 ? 16'hFFFF : 16'(n);
         slot   = $urandom_range(0, 3) == 0 ? -1 : $urandom_range(0, n - 1);
         build_exif(le, offset, count, n, slot, pick_code(), $urandom_range(0, 4));
         if (roll >= 75) begin
            // equal mark bytes, mostly neither of the legal two
            mark       = 8'($urandom);
            file_q[12] = mark;
            file_q[13] = mark;
         end else if (roll >= 65) begin
            file_q[$urandom_range(0, 19)] = 8'($urandom);
         end else if (roll >= 55) begin
            cut_file($urandom_range(1, file_q.size() - 1));
         end
      end
   endfunction

   // ---------------------------------------------------------------
   // Sender: bursts of back-to-back words with short gaps between.
   // Change inputs on the falling edge, sample ready on the rising.
   // ---------------------------------------------------------------
   task automatic send_byte(input logic [7:0] b, input logic eof);
      int gap;
      @(negedge clock);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         gap = $urandom_range(1, 6);
         repeat (gap) @(negedge clock);
         burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(80, 200)
                                                : $urandom_range(1, 24);
      end
      burst_left--;
      req_valid       <= 1'b1;
      req_byte_value  <= b;
      req_end_of_file <= eof;
      // hold the word until the block takes it
      do @(posedge clock); while (!req_ready);
      bytes_sent++;
   endtask

   task automatic send_file();
      foreach (file_q[i])
         send_byte(file_q[i], i == file_q.size() - 1);
   endtask

   // Drop valid, wait for every verdict, then give a trailing word time to
   // show up if the block makes one it should not.
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // ---------------------------------------------------------------
   // Receiver: cycle through stall patterns; on request, hold off for a
   // long stretch so the block backs up into its input.
   // ---------------------------------------------------------------
   always begin : rsp_pacer
      @(negedge clock);
      if (hold_request) begin
         hold_request = 1'b0;
         hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         if (pace_left == 0) begin
            pace      = pace_type'($urandom_range(0, 3));
            pace_left = $urandom_range(32, 200);
         end
         pace_left--;
         pace_tick++;
         case (pace)
            PACE_OPEN:   rsp_ready <= 1'b1;
            PACE_COIN:   rsp_ready <= 1'($urandom_range(0, 1));
            PACE_THIRDS: rsp_ready <= (pace_tick % 3) == 0;
            default:     rsp_ready <= $urandom_range(0, 3) == 0;
         endcase
      end
   end

   // End the run when nothing moves on either channel for too long.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("DONE: errors detected");
      $finish;
   end

   initial begin : stimulus
      int files;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // stream end on the very first word
      file_q.delete();
      file_q.push_back(8'hFF);
      send_file();
      // bad start marker; the word after the decision is ignored
      file_q.delete();
      file_q.push_back(8'h00);
      file_q.push_back(8'hAA);
      send_file();
      // smallest little-endian file, one entry, turn left
      build_exif(1'b1, 32'd8, 16'd1, 1, 0, jeos_pkg::ORIENT_LEFT, 1);
      send_file();
      // big-endian with two pad bytes, tag in the second entry, turn right
      build_exif(1'b0, 32'd10, 16'd2, 2, 1, jeos_pkg::ORIENT_RIGHT, 0);
      send_file();
      // byte-order mark halves disagree, file ends right after it
      build_exif(1'b1, 32'd8, 16'd1, 1, 0, 16'd0, 0);
      file_q[13] = jeos_pkg::BOM_BIG;
      cut_file(14);
      send_file();
      // offset pointing back into the header
      build_exif(1'b1, 32'd0, 16'd1, 0, -1, 16'd0, 1);
      send_file();
      // zero entry count
      build_exif(1'b0, 32'd8, 16'd0, 0, -1, 16'd0, 2);
      send_file();
      drain();

      files = 0;
      while (bytes_sent < TARGET_BYTES || files < MIN_FILES) begin
         // back the block up, then later let it run dry
         if (files == 8)
            hold_request = 1'b1;
         if (files == 16)
            drain();
         random_file();
         send_file();
         files++;
      end
      drain();

      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

// ===== files.f =====
sv/jeos_pkg.sv
sv/jeos_parser.sv
sv/jpeg_exif_orientation_scanner_unit.sv
sv/jeos_checker.sv
tb/exif_orientation_checker.sv
tb/tb_jpeg_exif_orientation_scanner_unit.sv
